/* src/rrtt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtt_pkg: shared types and constants for the round-robin task table
// Operation codes, the control part of the word that walks the cell chain,
// and the fixed field widths of the stream ports.
// ----------------------------------------------------------------------------
package rrtt_pkg;

    // Fixed field widths of the stream words
    localparam int FUNC_W      = 2;
    localparam int TASK_ID_W   = 8;
    localparam int SLOT_IDX_W  = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Operation carried in tuser
    typedef enum logic [FUNC_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    // Control part of the request word handed from cell to cell
    typedef struct packed {
        logic valid;  // a request sits in this stage
        op_t  op;     // operation of the request
        logic done;   // an earlier cell has already served it
    } tok_ctl_t;

endpackage

/* src/round_robin_task_table.sv */
`timescale 1ns / 1ps
// The request walks the slot chain, one cell per cycle while the output register
// is not full or is being read, and the next word enters as the result leaves the chain.
// A full output register holds the whole chain until the result is taken.
// Reset (rst_n low, asynchronous): every slot empty, pointer at slot zero, no word held.
// ----------------------------------------------------------------------------
// round_robin_task_table: round-robin task dispatcher table
// A row of task slot cells. Add fills the lowest empty slot, remove clears
// the lowest slot holding the identifier, tick reads the slot under the
// round-robin pointer and moves the pointer on.
// ----------------------------------------------------------------------------
module round_robin_task_table #(
    parameter int NUM_SLOTS = 32,
    parameter int ID_BITS   = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] task_id
    input  logic [rrtt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] func, [7:2] zero
    input  logic [rrtt_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] status, [1] run_valid, [9:2] run_task, [14:10] slot_index, [15] zero
    output logic [rrtt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import rrtt_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    tok_ctl_t               ctl_chain  [NUM_SLOTS+1];
    logic [ID_BITS-1:0]     id_chain   [NUM_SLOTS+1];
    logic [SLOT_W-1:0]      hit_chain  [NUM_SLOTS+1];
    logic [ID_BITS-1:0]     data_chain [NUM_SLOTS+1];

    logic                   advance;
    logic                   accept;
    logic                   exit_word;
    logic                   busy_reg;
    logic                   busy_next;
    logic [SLOT_W-1:0]      ptr_reg;
    logic [SLOT_W-1:0]      ptr_next;
    logic [ID_BITS-1:0]     in_id;
    tok_ctl_t               end_ctl;
    logic [ID_BITS-1:0]     end_data;
    logic [SLOT_W-1:0]      end_hit;
    logic [TASK_ID_W-1:0]   end_task;
    logic [SLOT_IDX_W-1:0]  end_slot;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // Handshake and chain movement
    assign advance       = !out_valid_reg || m_axis_tready;
    assign end_ctl       = ctl_chain[NUM_SLOTS];
    assign end_data      = data_chain[NUM_SLOTS];
    assign end_hit       = hit_chain[NUM_SLOTS];
    assign exit_word     = end_ctl.valid && advance;
    assign s_axis_tready = !busy_reg || exit_word;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Identifier narrowed or widened to ID_BITS
    generate
        if (ID_BITS >= TASK_ID_W)
        begin : g_id_wide
            assign in_id    = ID_BITS'(s_axis_tdata[TASK_ID_W-1:0]);
            assign end_task = end_data[TASK_ID_W-1:0];
        end
        else
        begin : g_id_narrow
            assign in_id    = s_axis_tdata[ID_BITS-1:0];
            assign end_task = TASK_ID_W'(end_data);
        end
        if (SLOT_W >= SLOT_IDX_W)
        begin : g_slot_wide
            assign end_slot = end_hit[SLOT_IDX_W-1:0];
        end
        else
        begin : g_slot_narrow
            assign end_slot = SLOT_IDX_W'(end_hit);
        end
    endgenerate

    // Request word entering the first cell
    always_comb
    begin
        ctl_chain[0].valid = accept;
        ctl_chain[0].op    = op_t'(s_axis_tuser[FUNC_W-1:0]);
        ctl_chain[0].done  = 1'b0;
        id_chain[0]        = in_id;
        hit_chain[0]       = '0;
        data_chain[0]      = '0;
    end

    // Row of slot cells
    generate
        for (genvar i = 0; i < NUM_SLOTS; i++)
        begin : g_cell
            rrtt_cell #(
                .ID_BITS (ID_BITS),
                .SLOT_W  (SLOT_W),
                .IDX     (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       ((i == 0) ? (advance || accept) : advance),
                .ptr      (ptr_reg),
                .in_ctl   (ctl_chain[i]),
                .in_id    (id_chain[i]),
                .in_hit   (hit_chain[i]),
                .in_data  (data_chain[i]),
                .out_ctl  (ctl_chain[i+1]),
                .out_id   (id_chain[i+1]),
                .out_hit  (hit_chain[i+1]),
                .out_data (data_chain[i+1])
            );
        end
    endgenerate

    // Result word from the end of the chain
    always_comb
    begin
        out_data_next = '0;
        case (end_ctl.op)
            OP_ADD, OP_REMOVE:
            begin
                out_data_next[0] = !end_ctl.done;
                if (end_ctl.done)
                    out_data_next[14:10] = end_slot;
            end
            OP_TICK:
            begin
                out_data_next[1]     = (end_data != '0);
                out_data_next[9:2]   = end_task;
                out_data_next[14:10] = end_slot;
            end
            default: out_data_next = '0;
        endcase
    end

    // Busy flag and round-robin pointer
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (exit_word)
            busy_next = 1'b0;

        ptr_next = ptr_reg;
        if (exit_word && end_ctl.op == OP_TICK)
            ptr_next = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ptr_reg  <= ptr_next;
            if (advance)
                out_valid_reg <= end_ctl.valid;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (exit_word)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* src/rrtt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtt_cell: one task slot of the chain
// Holds one slot and one stage of the request word. A request that has not
// been served yet is served here if this slot fits it; the word is then
// handed on to the next cell.
// ----------------------------------------------------------------------------
module rrtt_cell #(
    parameter int ID_BITS = 8,
    parameter int SLOT_W  = 5,
    parameter int IDX     = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [SLOT_W-1:0]     ptr,
    input  rrtt_pkg::tok_ctl_t    in_ctl,
    input  logic [ID_BITS-1:0]    in_id,
    input  logic [SLOT_W-1:0]     in_hit,
    input  logic [ID_BITS-1:0]    in_data,
    output rrtt_pkg::tok_ctl_t    out_ctl,
    output logic [ID_BITS-1:0]    out_id,
    output logic [SLOT_W-1:0]     out_hit,
    output logic [ID_BITS-1:0]    out_data
);
    import rrtt_pkg::*;

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

    tok_ctl_t            ctl_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [SLOT_W-1:0]   hit_reg;
    logic [ID_BITS-1:0]  data_reg;
    logic [ID_BITS-1:0]  slot_reg;
    logic [ID_BITS-1:0]  slot_next;
    logic                match;

    // Does this slot serve the request held here
    always_comb
    begin
        match = 1'b0;
        if (ctl_reg.valid && !ctl_reg.done)
        begin
            case (ctl_reg.op)
                OP_ADD:    match = (slot_reg == '0);
                OP_REMOVE: match = (slot_reg == id_reg);
                OP_TICK:   match = (ptr == MY_IDX);
                default:   match = 1'b0;
            endcase
        end
    end

    // New slot content
    always_comb
    begin
        slot_next = slot_reg;
        if (match)
        begin
            case (ctl_reg.op)
                OP_ADD:    slot_next = id_reg;
                OP_REMOVE: slot_next = '0;
                default:   slot_next = slot_reg;
            endcase
        end
    end

    // Word handed to the next cell
    always_comb
    begin
        out_ctl  = ctl_reg;
        out_id   = id_reg;
        out_hit  = hit_reg;
        out_data = data_reg;
        if (match)
        begin
            out_ctl.done = 1'b1;
            out_hit      = MY_IDX;
            out_data     = (ctl_reg.op == OP_TICK) ? slot_reg : '0;
        end
    end

    // Slot and control stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            ctl_reg  <= '0;
        end
        else if (en)
        begin
            slot_reg <= slot_next;
            ctl_reg  <= in_ctl;
        end
    end

    // Payload stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_reg   <= in_id;
            hit_reg  <= in_hit;
            data_reg <= in_data;
        end
    end

endmodule

/* test/round_robin_task_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_table_tb: self-checking bench for the round-robin task table
// Drives add, remove, tick and unknown operations over the input stream.
// A local copy of the slot table and pointer predicts every result word, and
// each word leaving the block is checked field by field against the oldest
// prediction. The sender idles in random bursts. The receiver stalls on
// patterns of its own, including one long hold-off that backs up the block.
// ----------------------------------------------------------------------------
module round_robin_task_table_tb;

    import rrtt_pkg::*;

    localparam int NUM_SLOTS   = 32;
    localparam int ID_BITS     = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_OPS  = 1100;

    // func value that the block has no operation for
    localparam logic [FUNC_W-1:0] OP_UNDEFINED = 2'd3;

    // One result word, highest field first as on m_axis_tdata
    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [TASK_ID_W-1:0]  run_task;
        logic                  run_valid;
        logic                  status;
    } dispatch_word_t;

    // Operation mix of a stretch of random traffic
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Mirror of the block state
    logic [ID_BITS-1:0]     slot_mirror [NUM_SLOTS];
    int                     rr_mirror;

    // Predicted result words, oldest first
    dispatch_word_t         dispatch_results_q [$];

    int                     error_count;
    int                     cycle_count;
    int                     burst_left;
    int                     hold_request;
    int                     hold_left;
    rx_mode_t               rx_mode;
    int                     rx_mode_left;
    int                     rx_period;
    int                     rx_phase;
    dispatch_word_t         seen_word;
    dispatch_word_t         due_word;

    // What the run reached
    int                     n_add_ok;
    int                     n_add_full;
    int                     n_rem_ok;
    int                     n_rem_miss;
    int                     n_tick_run;
    int                     n_tick_idle;
    int                     n_undef;

    round_robin_task_table #(
        .NUM_SLOTS (NUM_SLOTS),
        .ID_BITS   (ID_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d result words still awaited", $time,
                     dispatch_results_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Predict one operation and move the mirror on
    function automatic dispatch_word_t table_apply(input logic [FUNC_W-1:0] fn,
                                                   input logic [TASK_ID_W-1:0] id_in);
        dispatch_word_t     r;
        logic [ID_BITS-1:0] id;
        logic [ID_BITS-1:0] want;
        int                 hit;
        r    = '0;
        id   = id_in[ID_BITS-1:0];
        hit  = -1;
        if (fn == OP_ADD || fn == OP_REMOVE)
        begin
            // add looks for an empty slot, remove for the identifier
            want = (fn == OP_ADD) ? {ID_BITS{1'b0}} : id;
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
            begin
                if (slot_mirror[i] == want)
                    hit = i;
            end
            if (hit < 0)
            begin
                r.status = 1'b1;
                if (fn == OP_ADD)
                    n_add_full++;
                else
                    n_rem_miss++;
            end
            else
            begin
                slot_mirror[hit] = (fn == OP_ADD) ? id : {ID_BITS{1'b0}};
                r.slot_index     = SLOT_IDX_W'(hit);
                if (fn == OP_ADD)
                    n_add_ok++;
                else
                    n_rem_ok++;
            end
        end
        else if (fn == OP_TICK)
        begin
            r.slot_index = SLOT_IDX_W'(rr_mirror);
            if (slot_mirror[rr_mirror] != '0)
            begin
                r.run_valid = 1'b1;
                r.run_task  = TASK_ID_W'(slot_mirror[rr_mirror]);
                n_tick_run++;
            end
            else
                n_tick_idle++;
            rr_mirror = (rr_mirror + 1) % NUM_SLOTS;
        end
        else
            n_undef++;
        return r;
    endfunction

    function automatic int occupied_count();
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_mirror[i] != '0)
                n++;
        end
        return n;
    endfunction

    // Identifier of a random occupied slot; any identifier if the table is empty
    function automatic logic [TASK_ID_W-1:0] live_id();
        int n;
        int k;
        n = occupied_count();
        if (n == 0)
            return TASK_ID_W'($urandom_range(1, 255));
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_mirror[i] != '0)
            begin
                if (k == 0)
                    return TASK_ID_W'(slot_mirror[i]);
                k--;
            end
        end
        return '0;
    endfunction

    // Offer one word, wait for the handshake, then record its prediction.
    // Called at a rising edge; leaves tvalid high after acceptance.
    task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [TASK_ID_W-1:0] id);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= {{(IN_TUSER_W - FUNC_W){1'b0}}, fn};
        do
            @(posedge clk);
        while (!s_axis_tready);
        dispatch_results_q.push_back(table_apply(fn, id));
    endtask

    // One random operation, weighted by the mix
    task automatic send_random_op(input mix_t mix);
        int                    roll;
        int                    add_pct;
        int                    rem_pct;
        logic [FUNC_W-1:0]     fn;
        logic [TASK_ID_W-1:0]  id;
        case (mix)
            MIX_FILL:
            begin
                add_pct = 60;
                rem_pct = 15;
            end
            MIX_DRAIN:
            begin
                add_pct = 15;
                rem_pct = 60;
            end
            default:
            begin
                add_pct = 38;
                rem_pct = 32;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
        begin
            fn   = OP_ADD;
            // mostly fresh identifiers, some from a small pool for duplicates
            roll = $urandom_range(0, 99);
            if (roll < 65)
                id = TASK_ID_W'($urandom_range(1, 255));
            else if (roll < 85)
                id = TASK_ID_W'($urandom_range(1, 7));
            else if (roll < 92)
                id = '0;
            else
                id = '1;
        end
        else if (roll < add_pct + rem_pct)
        begin
            fn   = OP_REMOVE;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                id = live_id();
            else if (roll < 85)
                id = TASK_ID_W'($urandom_range(0, 255));
            else if (roll < 93)
                id = TASK_ID_W'($urandom_range(1, 7));
            else
                id = '0;
        end
        else if (roll < 96)
        begin
            fn = OP_TICK;
            id = TASK_ID_W'($urandom_range(0, 255));
        end
        else
        begin
            fn = OP_UNDEFINED;
            id = TASK_ID_W'($urandom_range(0, 255));
        end
        send_op(fn, id);
    endtask

    // Extremes and special cases on a freshly reset table
    task automatic test_directed_ops();
        send_op(OP_TICK,      8'h00);  // empty slot under the pointer
        send_op(OP_ADD,       8'h01);
        send_op(OP_ADD,       8'hFF);
        send_op(OP_ADD,       8'h00);  // succeeds, slot stays empty
        send_op(OP_REMOVE,    8'h00);  // matches lowest empty slot
        send_op(OP_ADD,       8'h80);
        send_op(OP_ADD,       8'h80);  // duplicate
        send_op(OP_REMOVE,    8'h80);  // lowest copy only
        send_op(OP_REMOVE,    8'h55);  // not found
        send_op(OP_UNDEFINED, 8'hAA);
        send_op(OP_TICK,      8'hFF);
        send_op(OP_TICK,      8'h55);
        send_op(OP_TICK,      8'hAA);
        send_op(OP_ADD,       8'h7F);
        send_op(OP_REMOVE,    8'hFF);
        send_op(OP_REMOVE,    8'h01);
        send_op(OP_UNDEFINED, 8'h55);
        send_op(OP_REMOVE,    8'h7F);
        send_op(OP_REMOVE,    8'h80);
        send_op(OP_TICK,      8'h00);
    endtask

    // Fill to full, push past it, tick a whole round, then drain to empty
    task automatic test_fill_and_drain();
        while (occupied_count() < NUM_SLOTS)
            send_op(OP_ADD, TASK_ID_W'($urandom_range(1, 255)));
        send_op(OP_ADD, TASK_ID_W'($urandom_range(1, 255)));
        send_op(OP_ADD, 8'h00);
        send_op(OP_REMOVE, 8'h00);    // no empty slot to match
        repeat (NUM_SLOTS + 2)
            send_op(OP_TICK, TASK_ID_W'($urandom_range(0, 255)));
        send_op(OP_REMOVE, live_id());
        send_op(OP_ADD, TASK_ID_W'($urandom_range(1, 255)));
        while (occupied_count() > 0)
            send_op(OP_REMOVE, live_id());
        send_op(OP_REMOVE, TASK_ID_W'($urandom_range(1, 255)));
        send_op(OP_TICK, 8'h00);
    endtask

    // Random traffic in stretches that fill, drain or hold the table level
    task automatic test_random_mix();
        int   sent;
        int   stretch;
        mix_t mix;
        sent = 0;
        while (sent < RANDOM_OPS)
        begin
            mix     = mix_t'($urandom_range(0, 2));
            stretch = $urandom_range(40, 120);
            repeat (stretch)
            begin
                send_random_op(mix);
                sent++;
            end
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_output_hold_off();
        hold_request = 400;
        repeat (24)
            send_random_op(MIX_EVEN);
    endtask

    // Receiver stall patterns, plus the long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 300);
                rx_period    = $urandom_range(2, 9);
            end
            rx_mode_left--;
            rx_phase = (rx_phase + 1) % rx_period;
            case (rx_mode)
                RX_OPEN:     m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 7) == 0);
                default:     m_axis_tready <= (rx_phase == 0);
            endcase
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_word = dispatch_word_t'(m_axis_tdata[$bits(dispatch_word_t)-1:0]);
            if (dispatch_results_q.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %0h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                due_word = dispatch_results_q.pop_front();
                compare_field("status",     due_word.status,     seen_word.status);
                compare_field("run_valid",  due_word.run_valid,  seen_word.run_valid);
                compare_field("run_task",   due_word.run_task,   seen_word.run_task);
                compare_field("slot_index", due_word.slot_index, seen_word.slot_index);
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        burst_left    = 0;
        hold_request  = 0;
        hold_left     = 0;
        rx_mode       = RX_OPEN;
        rx_mode_left  = 0;
        rx_period     = 2;
        rx_phase      = 0;
        rr_mirror     = 0;
        n_add_ok      = 0;
        n_add_full    = 0;
        n_rem_ok      = 0;
        n_rem_miss    = 0;
        n_tick_run    = 0;
        n_tick_idle   = 0;
        n_undef       = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_mirror[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        test_fill_and_drain();
        test_output_hold_off();
        test_random_mix();
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then watch for stray words
        while (dispatch_results_q.size() != 0)
            @(posedge clk);
        repeat (2 * NUM_SLOTS + 8) @(posedge clk);

        $display("Adds placed %0d, adds on a full table %0d, removes hit %0d, missed %0d",
                 n_add_ok, n_add_full, n_rem_ok, n_rem_miss);
        $display("Ticks that ran a task %0d, ticks on an empty slot %0d, unknown ops %0d",
                 n_tick_run, n_tick_idle, n_undef);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
src/rrtt_pkg.sv
src/rrtt_cell.sv
src/round_robin_task_table.sv
test/round_robin_task_table_tb.sv
